// File: hw/rtl/plen_pkg.sv
// ----------------------------------------------------------------------------
// plen_pkg: shared definitions for the positional list engine
// Sizes, operation and status codes, and the request and response structs
// of the shared index unit.
// ----------------------------------------------------------------------------
package plen_pkg;

   // Largest number of elements held in the list.
   localparam int DEPTH = 32;

   // Field widths.
   localparam int OPW = 3;
   localparam int PW  = 8;
   localparam int VW  = 32;
   localparam int STW = 2;

   // Element address and element count widths.
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   // Stream data widths, padded to whole bytes.
   localparam int REQ_TDW = ((PW + VW + 7) / 8) * 8;
   localparam int RSP_TDW = ((STW + VW + 7) / 8) * 8;

   // Operation codes.
   typedef enum logic [OPW-1:0] {
      OP_APPEND  = 3'd0,
      OP_INSERT  = 3'd1,
      OP_DELETE  = 3'd2,
      OP_READ    = 3'd3,
      OP_REVERSE = 3'd4
   } op_type;

   // Result status codes.
   typedef enum logic [STW-1:0] {
      ST_OK     = 2'd0,
      ST_BADPOS = 2'd1,
      ST_FULL   = 2'd2
   } status_type;

   // Request to the shared index unit: one increment or decrement and one
   // compare per cycle.
   typedef struct packed {
      logic [PW-1:0] a;
      logic [PW-1:0] b;
      logic          dec;
      logic          use_res;
      logic          swap;
   } unit_req_type;

   // Response of the shared index unit.
   typedef struct packed {
      logic [PW-1:0] res;
      logic          lt;
   } unit_rsp_type;

endpackage

// File: hw/rtl/positional_list_engine_core.sv
// Append, read, errors and reverse of up to one element pass the dispatch
// and result states and present their single result from the result register.
// Insert and delete shift each element by a read and a write, reverse swaps each
// pair by reads and writes, and the list stream after insert or delete can stall.
// Throughput: one operation at a time on the single RAM port pair.
// Reset (synchronous, active high) empties the list; memory is not cleared.
// ----------------------------------------------------------------------------
// positional_list_engine_core: ordered list with positional operations
// Append, insert, delete, read and reverse on a list of up to DEPTH signed
// values held in one RAM, with the list streamed after insert and delete.
// ----------------------------------------------------------------------------
module positional_list_engine_core (
   input  logic                         clock,
   input  logic                         reset,
   // Operation transactions.
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // [7:0] position, [39:8] value
   input  logic [plen_pkg::REQ_TDW-1:0] req_tdata,
   // [2:0] op
   input  logic [plen_pkg::OPW-1:0]     req_tuser,
   // Result transactions.
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // [1:0] status, [33:2] element, [39:34] zero
   output logic [plen_pkg::RSP_TDW-1:0] rsp_tdata,
   // [0] has_value
   output logic                         rsp_tuser,
   output logic                         rsp_tlast
);
   import plen_pkg::*;

   unit_req_type   unit_req;
   unit_rsp_type   unit_rsp;
   logic           ram_we;
   logic [AW-1:0]  ram_waddr;
   logic [VW-1:0]  ram_wdata;
   logic           ram_re;
   logic [AW-1:0]  ram_raddr;
   logic [VW-1:0]  ram_rdata;
   logic [STW-1:0] rsp_status;
   logic [VW-1:0]  rsp_elem;

   // Sequencer with the result register.
   plen_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .req_pos    (req_tdata[PW-1:0]),
      .req_val    (req_tdata[PW +: VW]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_status (rsp_status),
      .rsp_hv     (rsp_tuser),
      .rsp_elem   (rsp_elem),
      .rsp_last   (rsp_tlast),
      .unit_req   (unit_req),
      .unit_rsp   (unit_rsp),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_re     (ram_re),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata)
   );

   // Shared index step and compare.
   plen_idx_unit u_idx_unit (
      .req (unit_req),
      .rsp (unit_rsp)
   );

   // List element storage.
   plen_ram #(
      .WIDTH (VW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Pack the result fields, zero padding above the element.
   assign rsp_tdata = {{(RSP_TDW - STW - VW){1'b0}}, rsp_elem, rsp_status};

endmodule

// File: hw/rtl/plen_ram.sv
// ----------------------------------------------------------------------------
// plen_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds until the
// next read.
// ----------------------------------------------------------------------------
module plen_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/plen_idx_unit.sv
// ----------------------------------------------------------------------------
// plen_idx_unit: shared index arithmetic
// Adds or subtracts one and compares either the operand or the result
// against a second operand. Every position and count step goes through it.
// ----------------------------------------------------------------------------
module plen_idx_unit (
   input  plen_pkg::unit_req_type req,
   output plen_pkg::unit_rsp_type rsp
);
   import plen_pkg::*;

   logic [PW-1:0] res;
   logic [PW-1:0] x;

   // Step by one, wrapping at the operand width.
   assign res = req.dec ? (req.a - PW'(1)) : (req.a + PW'(1));

   // Compare the chosen value against b, either way round.
   assign x = req.use_res ? res : req.a;

   assign rsp.res = res;
   assign rsp.lt  = req.swap ? (req.b < x) : (x < req.b);

endmodule

// File: hw/rtl/plen_seq.sv
// ----------------------------------------------------------------------------
// plen_seq: operation sequencer of the positional list engine
// Checks each operation, walks the list memory for shift, reverse and
// stream passes using the shared index unit, and holds the result register.
// ----------------------------------------------------------------------------
module plen_seq (
   input  logic                   clock,
   input  logic                   reset,
   // Operation transactions.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [plen_pkg::OPW-1:0] req_op,
   input  logic [plen_pkg::PW-1:0]  req_pos,
   input  logic [plen_pkg::VW-1:0]  req_val,
   // Result transactions.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [plen_pkg::STW-1:0] rsp_status,
   output logic                   rsp_hv,
   output logic [plen_pkg::VW-1:0]  rsp_elem,
   output logic                   rsp_last,
   // Shared index unit.
   output plen_pkg::unit_req_type unit_req,
   input  plen_pkg::unit_rsp_type unit_rsp,
   // List memory.
   output logic                   ram_we,
   output logic [plen_pkg::AW-1:0]  ram_waddr,
   output logic [plen_pkg::VW-1:0]  ram_wdata,
   output logic                   ram_re,
   output logic [plen_pkg::AW-1:0]  ram_raddr,
   input  logic [plen_pkg::VW-1:0]  ram_rdata
);
   import plen_pkg::*;

   typedef enum logic [15:0] {
      S_IDLE     = 16'h0001,
      S_DISP     = 16'h0002,
      S_INS_RD   = 16'h0004,
      S_INS_WR   = 16'h0008,
      S_INS_PUT  = 16'h0010,
      S_DEL_RD   = 16'h0020,
      S_DEL_WR   = 16'h0040,
      S_DEL_END  = 16'h0080,
      S_STR_RD   = 16'h0100,
      S_STR_OUT  = 16'h0200,
      S_REV_INIT = 16'h0400,
      S_REV_RA   = 16'h0800,
      S_REV_RB   = 16'h1000,
      S_REV_WA   = 16'h2000,
      S_REV_WB   = 16'h4000,
      S_ONE      = 16'h8000
   } state_type;

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    idx_ff, idx_in;
   logic [AW-1:0]    wr_ff, wr_in;
   logic [AW-1:0]    hi_ff, hi_in;
   logic [AW-1:0]    pm1_ff, pm1_in;
   op_type           op_ff, op_in;
   logic [PW-1:0]    pos_ff, pos_in;
   logic [VW-1:0]    val_ff, val_in;
   logic [VW-1:0]    tmp_ff, tmp_in;
   status_type       status_ff, status_in;
   logic             hv_ff, hv_in;
   logic             last_ff, last_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [STW-1:0]   rsp_status_ff, rsp_status_in;
   logic             rsp_hv_ff, rsp_hv_in;
   logic [VW-1:0]    rsp_elem_ff, rsp_elem_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             slot_free;
   logic             full;
   logic             empty;

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);

   // Sequencer next-state logic.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      wr_in         = wr_ff;
      hi_in         = hi_ff;
      pm1_in        = pm1_ff;
      op_in         = op_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      tmp_in        = tmp_ff;
      status_in     = status_ff;
      hv_in         = hv_ff;
      last_in       = last_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_hv_in     = rsp_hv_ff;
      rsp_elem_in   = rsp_elem_ff;
      rsp_last_in   = rsp_last_ff;

      unit_req      = '{a: '0, b: '0, dec: 1'b0, use_res: 1'b0, swap: 1'b0};
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = val_ff;
      ram_re        = 1'b0;
      ram_raddr     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = op_type'(req_op);
               pos_in   = req_pos;
               val_in   = req_val;
               state_in = S_DISP;
            end
         end

         // Check the position and fullness, and finish the short operations.
         S_DISP: begin
            unique case (op_ff)
               OP_APPEND: begin
                  unit_req.a = PW'(count_ff);
                  if (full) begin
                     status_in = ST_FULL;
                  end else begin
                     ram_we    = 1'b1;
                     ram_waddr = count_ff[AW-1:0];
                     count_in  = unit_rsp.res[CW-1:0];
                     status_in = ST_OK;
                  end
                  state_in = S_ONE;
               end
               OP_INSERT, OP_DELETE, OP_READ: begin
                  // pos - 1 < count holds exactly for 1 <= pos <= count.
                  unit_req.a       = pos_ff;
                  unit_req.b       = PW'(count_ff);
                  unit_req.dec     = 1'b1;
                  unit_req.use_res = 1'b1;
                  pm1_in           = unit_rsp.res[AW-1:0];
                  if (!unit_rsp.lt) begin
                     status_in = ST_BADPOS;
                     state_in  = S_ONE;
                  end else if (op_ff == OP_INSERT) begin
                     if (full) begin
                        status_in = ST_FULL;
                        state_in  = S_ONE;
                     end else begin
                        idx_in   = count_ff;
                        state_in = S_INS_RD;
                     end
                  end else if (op_ff == OP_DELETE) begin
                     idx_in   = unit_rsp.res[CW-1:0];
                     state_in = S_DEL_RD;
                  end else begin
                     ram_re    = 1'b1;
                     ram_raddr = unit_rsp.res[AW-1:0];
                     hv_in     = 1'b1;
                     status_in = ST_OK;
                     state_in  = S_ONE;
                  end
               end
               OP_REVERSE: begin
                  // Only a list of two or more elements needs swapping.
                  unit_req.a = PW'(1);
                  unit_req.b = PW'(count_ff);
                  status_in  = ST_OK;
                  state_in   = unit_rsp.lt ? S_REV_INIT : S_ONE;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end

         // Insert: move each element from the tail down to the position
         // one place up.
         S_INS_RD: begin
            unit_req.a   = PW'(idx_ff);
            unit_req.dec = 1'b1;
            ram_re       = 1'b1;
            ram_raddr    = unit_rsp.res[AW-1:0];
            wr_in        = idx_ff[AW-1:0];
            idx_in       = unit_rsp.res[CW-1:0];
            state_in     = S_INS_WR;
         end

         S_INS_WR: begin
            ram_we     = 1'b1;
            ram_waddr  = wr_ff;
            ram_wdata  = ram_rdata;
            unit_req.a = PW'(pm1_ff);
            unit_req.b = PW'(idx_ff);
            state_in   = unit_rsp.lt ? S_INS_RD : S_INS_PUT;
         end

         S_INS_PUT: begin
            ram_we     = 1'b1;
            ram_waddr  = pm1_ff;
            ram_wdata  = val_ff;
            unit_req.a = PW'(count_ff);
            count_in   = unit_rsp.res[CW-1:0];
            idx_in     = '0;
            state_in   = S_STR_RD;
         end

         // Delete: move each element after the position one place down.
         S_DEL_RD: begin
            unit_req.a       = PW'(idx_ff);
            unit_req.b       = PW'(count_ff);
            unit_req.use_res = 1'b1;
            if (unit_rsp.lt) begin
               ram_re    = 1'b1;
               ram_raddr = unit_rsp.res[AW-1:0];
               wr_in     = idx_ff[AW-1:0];
               idx_in    = unit_rsp.res[CW-1:0];
               state_in  = S_DEL_WR;
            end else begin
               state_in  = S_DEL_END;
            end
         end

         S_DEL_WR: begin
            ram_we    = 1'b1;
            ram_waddr = wr_ff;
            ram_wdata = ram_rdata;
            state_in  = S_DEL_RD;
         end

         S_DEL_END: begin
            unit_req.a   = PW'(count_ff);
            unit_req.dec = 1'b1;
            count_in     = unit_rsp.res[CW-1:0];
            idx_in       = '0;
            state_in     = S_STR_RD;
         end

         // Stream the list, one element per read.
         S_STR_RD: begin
            if (empty) begin
               status_in = ST_OK;
               hv_in     = 1'b0;
               state_in  = S_ONE;
            end else begin
               unit_req.a       = PW'(idx_ff);
               unit_req.b       = PW'(count_ff);
               unit_req.use_res = 1'b1;
               ram_re           = 1'b1;
               ram_raddr        = idx_ff[AW-1:0];
               last_in          = !unit_rsp.lt;
               idx_in           = unit_rsp.res[CW-1:0];
               state_in         = S_STR_OUT;
            end
         end

         S_STR_OUT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_hv_in     = 1'b1;
               rsp_elem_in   = ram_rdata;
               rsp_last_in   = last_ff;
               state_in      = last_ff ? S_IDLE : S_STR_RD;
            end
         end

         // Reverse: swap the outermost pair and close in from both ends.
         S_REV_INIT: begin
            unit_req.a   = PW'(count_ff);
            unit_req.dec = 1'b1;
            hi_in        = unit_rsp.res[AW-1:0];
            idx_in       = '0;
            state_in     = S_REV_RA;
         end

         S_REV_RA: begin
            ram_re    = 1'b1;
            ram_raddr = idx_ff[AW-1:0];
            state_in  = S_REV_RB;
         end

         S_REV_RB: begin
            tmp_in    = ram_rdata;
            ram_re    = 1'b1;
            ram_raddr = hi_ff;
            state_in  = S_REV_WA;
         end

         S_REV_WA: begin
            ram_we     = 1'b1;
            ram_waddr  = idx_ff[AW-1:0];
            ram_wdata  = ram_rdata;
            unit_req.a = PW'(idx_ff);
            idx_in     = unit_rsp.res[CW-1:0];
            state_in   = S_REV_WB;
         end

         S_REV_WB: begin
            ram_we           = 1'b1;
            ram_waddr        = hi_ff;
            ram_wdata        = tmp_ff;
            unit_req.a       = PW'(hi_ff);
            unit_req.b       = PW'(idx_ff);
            unit_req.dec     = 1'b1;
            unit_req.use_res = 1'b1;
            unit_req.swap    = 1'b1;
            hi_in            = unit_rsp.res[AW-1:0];
            if (unit_rsp.lt) begin
               state_in  = S_REV_RA;
            end else begin
               status_in = ST_OK;
               state_in  = S_ONE;
            end
         end

         // Single result: status, and the read value when there is one.
         S_ONE: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_hv_in     = hv_ff;
               rsp_elem_in   = hv_ff ? ram_rdata : '0;
               rsp_last_in   = 1'b1;
               hv_in         = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         hv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         hv_ff        <= hv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      wr_ff         <= wr_in;
      hi_ff         <= hi_in;
      pm1_ff        <= pm1_in;
      op_ff         <= op_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      tmp_ff        <= tmp_in;
      status_ff     <= status_in;
      last_ff       <= last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_hv_ff     <= rsp_hv_in;
      rsp_elem_ff   <= rsp_elem_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_hv     = rsp_hv_ff;
   assign rsp_elem   = rsp_elem_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

// File: hw/rtl/plen_checker.sv
// ----------------------------------------------------------------------------
// plen_checker: port-level checks for the positional list engine
// Watches the stream ports for held results, busy behavior and consistent
// result fields; bound to the top level.
// ----------------------------------------------------------------------------
module plen_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic [plen_pkg::OPW-1:0]     req_tuser,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [plen_pkg::RSP_TDW-1:0] rsp_tdata,
   input logic                         rsp_tuser,
   input logic                         rsp_tlast
);
   import plen_pkg::*;

   // A stalled result keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("result changed while stalled");

   // An accepted append or read leaves the block busy next.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == OP_APPEND || req_tuser == OP_READ))
         |=> !req_tready)
      else $error("operation accepted without going busy");

   // A carried value only comes with an ok status.
   a_value_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[STW-1:0] == ST_OK))
      else $error("value carried with an error status");

   // Error results are single and carry a zero element.
   a_error_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[STW-1:0] != ST_OK)
         |-> (rsp_tlast && !rsp_tuser && rsp_tdata[STW +: VW] == '0))
      else $error("error result not a single empty result");

   // A result without a value has a zero element.
   a_empty_element: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[STW +: VW] == '0))
      else $error("element nonzero without a value");

endmodule

bind positional_list_engine_core plen_checker u_plen_checker (.*);
